// ===== rtl/core/jpq_pkg.sv =====
// ----------------------------------------------------------------------------
// jpq_pkg
// Shared types, constants and index helpers for the sorted job priority queue.
// ----------------------------------------------------------------------------
package jpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W  = 32;
    localparam int KEY_W   = TIME_W + 1;
    localparam int TAG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] submit;
        logic [TIME_W-1:0] delay;
        logic [TAG_W-1:0]  tag;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    // circular slot index, wraps at the queue depth
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = idx + IDX_W'(1);
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0)
            res = IDX_W'(QUEUE_DEPTH - 1);
        else
            res = idx - IDX_W'(1);
        return res;
    endfunction

endpackage

// ===== rtl/core/jpq_ram.sv =====
// ----------------------------------------------------------------------------
// jpq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module jpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sorted_job_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_job_priority_queue_core
// Bounded priority queue of jobs ordered by start key (submit time + delay).
// ----------------------------------------------------------------------------
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-------------------------------------
//   request   | req_valid in, req_stall out| cmd, submit_time, delay, job_tag
//   result    | res_valid out, res_stall in| status, out_tag, out_submit,
//             |                            | out_delay, entry_count
//
// - insert walks back over the n held jobs whose key is larger than the new
//   one, then writes it; remove reads the head; a refused insert or a remove
//   on an empty queue goes straight to the result
// - the job memory has one read and one write port, so the insert walk moves
//   one entry per cycle
// - rst_n clears the pointers, the count, the handshake state and the working
//   registers; the memory itself is never cleared, only slots below the count
//   are ever read
// - a result waits in the output register while the next request is worked on;
//   req_stall is high while a request is in progress
//
// the jobs live in a circular buffer: head is the earliest job, tail the first
// free slot. remove reads the head and advances it. insert walks back from the
// tail, moving every job with a larger key up by one slot, then drops the new
// job into the hole, so equal keys keep arrival order.
module sorted_job_priority_queue_core
    import jpq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                req_valid,
    output logic                req_stall,
    input  logic                cmd,
    input  logic [TIME_W-1:0]   submit_time,
    input  logic [TIME_W-1:0]   delay,
    input  logic [TAG_W-1:0]    job_tag,

    output logic                res_valid,
    input  logic                res_stall,
    output logic [STAT_W-1:0]   status,
    output logic [TAG_W-1:0]    out_tag,
    output logic [TIME_W-1:0]   out_submit,
    output logic [TIME_W-1:0]   out_delay,
    output logic [ECNT_W-1:0]   entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PLACE,
        S_REM_DATA,
        S_RESULT
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   wr_ptr_reg;   // hole that the walk is filling
    logic [CNT_W-1:0]   walk_reg;     // held jobs still below the hole
    job_t               job_reg;      // job of the request in progress

    // pending result
    logic [STAT_W-1:0]  pend_status_reg;
    logic [TAG_W-1:0]   pend_tag_reg;
    logic [TIME_W-1:0]  pend_submit_reg;
    logic [TIME_W-1:0]  pend_delay_reg;

    // output register
    logic               res_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [TIME_W-1:0]  out_submit_reg;
    logic [TIME_W-1:0]  out_delay_reg;
    logic [ECNT_W-1:0]  entry_count_reg;

    // memory port
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    job_t               ram_wr_job;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [JOB_W-1:0]   ram_rd_data;
    job_t               rd_job;

    logic               req_take;
    logic               queue_full;
    logic               queue_empty;
    logic               shift_up;     // held job has a larger key than the new one
    logic               out_free;
    logic [31:0]        count_wide;
    job_t               new_job;

    assign req_take    = req_valid && (state_reg == S_IDLE);
    assign queue_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);
    assign rd_job      = job_t'(ram_rd_data);
    assign shift_up    = (rd_job.key > job_reg.key);
    assign out_free    = !res_valid_reg || !res_stall;
    assign count_wide  = 32'(count_reg);

    always_comb
    begin
        new_job.key    = {1'b0, submit_time} + {1'b0, delay};
        new_job.submit = submit_time;
        new_job.delay  = delay;
        new_job.tag    = job_tag;
    end

    // memory control
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_ptr_reg;
        ram_wr_job  = job_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_prev(tail_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !queue_empty)
                begin
                    if (cmd == CMD_INSERT)
                    begin
                        ram_rd_en = !queue_full;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_reg;
                    end
                end
            end
            S_INS_CMP:
            begin
                ram_wr_en = 1'b1;
                if (shift_up)
                begin
                    ram_wr_job = rd_job;
                    // prefetch the next lower job while this one moves up
                    if (walk_reg != CNT_W'(1))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_prev(idx_prev(wr_ptr_reg));
                    end
                end
            end
            S_INS_PLACE:
            begin
                ram_wr_en = 1'b1;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            wr_ptr_reg      <= '0;
            walk_reg        <= '0;
            job_reg         <= '0;
            pend_status_reg <= ST_INSERTED;
            pend_tag_reg    <= '0;
            pend_submit_reg <= '0;
            pend_delay_reg  <= '0;
            res_valid_reg   <= 1'b0;
            status_reg      <= ST_INSERTED;
            out_tag_reg     <= '0;
            out_submit_reg  <= '0;
            out_delay_reg   <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            // the result state reloads the output register itself
            if (res_valid_reg && !res_stall && (state_reg != S_RESULT))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        job_reg         <= new_job;
                        pend_tag_reg    <= '0;
                        pend_submit_reg <= '0;
                        pend_delay_reg  <= '0;
                        wr_ptr_reg      <= tail_reg;
                        walk_reg        <= count_reg;
                        if (cmd == CMD_INSERT)
                        begin
                            if (queue_full)
                            begin
                                pend_status_reg <= ST_FULL;
                                state_reg       <= S_RESULT;
                            end
                            else if (queue_empty)
                            begin
                                state_reg <= S_INS_PLACE;
                            end
                            else
                            begin
                                state_reg <= S_INS_CMP;
                            end
                        end
                        else
                        begin
                            if (queue_empty)
                            begin
                                pend_status_reg <= ST_EMPTY;
                                state_reg       <= S_RESULT;
                            end
                            else
                            begin
                                state_reg <= S_REM_DATA;
                            end
                        end
                    end
                end
                S_INS_CMP:
                begin
                    if (shift_up)
                    begin
                        wr_ptr_reg <= idx_prev(wr_ptr_reg);
                        walk_reg   <= walk_reg - CNT_W'(1);
                        if (walk_reg == CNT_W'(1))
                        begin
                            state_reg <= S_INS_PLACE;
                        end
                    end
                    else
                    begin
                        // new job written into the hole this cycle
                        tail_reg        <= idx_next(tail_reg);
                        count_reg       <= count_reg + CNT_W'(1);
                        pend_status_reg <= ST_INSERTED;
                        state_reg       <= S_RESULT;
                    end
                end
                S_INS_PLACE:
                begin
                    tail_reg        <= idx_next(tail_reg);
                    count_reg       <= count_reg + CNT_W'(1);
                    pend_status_reg <= ST_INSERTED;
                    state_reg       <= S_RESULT;
                end
                S_REM_DATA:
                begin
                    head_reg        <= idx_next(head_reg);
                    count_reg       <= count_reg - CNT_W'(1);
                    pend_status_reg <= ST_REMOVED;
                    pend_tag_reg    <= rd_job.tag;
                    pend_submit_reg <= rd_job.submit;
                    pend_delay_reg  <= rd_job.delay;
                    state_reg       <= S_RESULT;
                end
                S_RESULT:
                begin
                    // hand over once the output register is free or emptying
                    if (out_free)
                    begin
                        res_valid_reg   <= 1'b1;
                        status_reg      <= pend_status_reg;
                        out_tag_reg     <= pend_tag_reg;
                        out_submit_reg  <= pend_submit_reg;
                        out_delay_reg   <= pend_delay_reg;
                        entry_count_reg <= count_wide[ECNT_W-1:0];
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    jpq_ram #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_job),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign req_stall   = (state_reg != S_IDLE);
    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign out_tag     = out_tag_reg;
    assign out_submit  = out_submit_reg;
    assign out_delay   = out_delay_reg;
    assign entry_count = entry_count_reg;

endmodule

// ===== test/sorted_job_priority_queue_core_test.sv =====
// ----------------------------------------------------------------------------
// sorted_job_priority_queue_core_test
// Self-checking bench for the sorted job priority queue: drives insert and
// remove requests with random gaps and result stalls, predicts each result
// with its own ordered job list and compares every field of every result.
// ----------------------------------------------------------------------------
module sorted_job_priority_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jpq_pkg::*;

    // generous cycle budget: every request a long gap, a full walk and a long stall
    localparam int CYCLE_LIMIT = 800_000;
    localparam int RANDOM_REQS = 1830;

    // one queued request, or a hold-off marker that waits for every result
    typedef struct {
        logic              hold;
        logic              cmd;
        logic [TIME_W-1:0] submit;
        logic [TIME_W-1:0] delay;
        logic [TAG_W-1:0]  tag;
    } job_cmd_t;

    // what the block should answer for one request
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] submit;
        logic [TIME_W-1:0] delay;
        logic [ECNT_W-1:0] count;
    } outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic              cmd = CMD_INSERT;
    logic [TIME_W-1:0] submit_time = '0;
    logic [TIME_W-1:0] delay = '0;
    logic [TAG_W-1:0]  job_tag = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  out_tag;
    logic [TIME_W-1:0] out_submit;
    logic [TIME_W-1:0] out_delay;
    logic [ECNT_W-1:0] entry_count;

    job_cmd_t job_cmds[$];       // requests still to be driven
    outcome_t due_outcomes[$];   // predicted results, oldest first

    // shadow of the queue contents, ascending key, entry 0 is the head
    job_t shadow_jobs[QUEUE_DEPTH];
    int   shadow_count = 0;

    logic req_taken = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   fail_count = 0;
    int   n_insert = 0;
    int   n_remove = 0;
    int   n_empty = 0;
    int   n_full = 0;
    int   n_results = 0;
    int   deepest = 0;

    sorted_job_priority_queue_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .submit_time (submit_time),
        .delay       (delay),
        .job_tag     (job_tag),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .out_tag     (out_tag),
        .out_submit  (out_submit),
        .out_delay   (out_delay),
        .entry_count (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // key values: small ranges give lots of equal keys, the rest spans all bits
    function automatic logic [TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return TIME_W'($urandom_range(0, 31));
        else if (r < 80)
            return $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return 32'h8000_0000;
                default: return 32'h7fff_ffff;
            endcase
        end
    endfunction

    task automatic add_insert(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] d,
                              input logic [TAG_W-1:0] t);
        job_cmd_t c;
        c.hold   = 1'b0;
        c.cmd    = CMD_INSERT;
        c.submit = s;
        c.delay  = d;
        c.tag    = t;
        job_cmds.push_back(c);
    endtask

    task automatic add_remove();
        job_cmd_t c;
        c.hold   = 1'b0;
        c.cmd    = CMD_REMOVE;
        // payload is don't-care for a remove, still toggle it
        c.submit = $urandom;
        c.delay  = $urandom;
        c.tag    = TAG_W'($urandom);
        job_cmds.push_back(c);
    endtask

    task automatic add_hold();
        job_cmd_t c;
        c = '{hold: 1'b1, cmd: CMD_INSERT, submit: '0, delay: '0, tag: '0};
        job_cmds.push_back(c);
    endtask

    // advance the shadow queue by one request and return the answer it gives
    function automatic outcome_t apply_job_cmd(input logic c_cmd,
                                               input logic [TIME_W-1:0] c_sub,
                                               input logic [TIME_W-1:0] c_dly,
                                               input logic [TAG_W-1:0] c_tag);
        outcome_t o;
        job_t     j;
        int       pos;
        o = '{status: ST_INSERTED, tag: '0, submit: '0, delay: '0, count: '0};
        if (c_cmd == CMD_INSERT)
        begin
            if (shadow_count >= QUEUE_DEPTH)
                o.status = ST_FULL;
            else
            begin
                // 33-bit start key, no wrap
                j.key    = {1'b0, c_sub} + {1'b0, c_dly};
                j.submit = c_sub;
                j.delay  = c_dly;
                j.tag    = c_tag;
                // equal keys go behind, so arrival order holds among ties
                pos = 0;
                while (pos < shadow_count && shadow_jobs[pos].key <= j.key)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_jobs[i] = shadow_jobs[i-1];
                shadow_jobs[pos] = j;
                shadow_count++;
                o.status = ST_INSERTED;
            end
        end
        else if (shadow_count == 0)
            o.status = ST_EMPTY;
        else
        begin
            o.status = ST_REMOVED;
            o.tag    = shadow_jobs[0].tag;
            o.submit = shadow_jobs[0].submit;
            o.delay  = shadow_jobs[0].delay;
            for (int i = 1; i < shadow_count; i++)
                shadow_jobs[i-1] = shadow_jobs[i];
            shadow_count--;
        end
        o.count = ECNT_W'(shadow_count);
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // request driver: changes on the falling edge, holds a stalled request
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap  <= send_gap - 1;
                req_valid <= 1'b0;
            end
            else if (job_cmds.size() == 0)
                req_valid <= 1'b0;
            else if (job_cmds[0].hold)
            begin
                // hold-off: nothing new until every result is back
                if (due_outcomes.size() == 0)
                    void'(job_cmds.pop_front());
                req_valid <= 1'b0;
            end
            else
            begin
                cmd         <= job_cmds[0].cmd;
                submit_time <= job_cmds[0].submit;
                delay       <= job_cmds[0].delay;
                job_tag     <= job_cmds[0].tag;
                req_valid   <= 1'b1;
                send_gap    <= pick_gap();
                void'(job_cmds.pop_front());
            end
        end
    end

    // result stall: random stalled and free stretches, some of them long
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(0, 99) < 40)
        begin
            res_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
        else
        begin
            res_stall  <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    end

    // monitor: samples both handshakes on the rising edge
    always @(posedge clk)
    begin
        outcome_t o;
        outcome_t w;
        if (rst_n)
        begin
            cycle_count++;
            if (res_valid && !res_stall)
            begin
                n_results++;
                if (due_outcomes.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d", status);
                    fail_count++;
                end
                else
                begin
                    w = due_outcomes.pop_front();
                    check_field("status", 32'(w.status), 32'(status));
                    check_field("out_tag", 32'(w.tag), 32'(out_tag));
                    check_field("out_submit", w.submit, out_submit);
                    check_field("out_delay", w.delay, out_delay);
                    check_field("entry_count", 32'(w.count), 32'(entry_count));
                end
            end
            req_taken <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                o = apply_job_cmd(cmd, submit_time, delay, job_tag);
                due_outcomes.push_back(o);
                case (o.status)
                    ST_INSERTED: n_insert++;
                    ST_REMOVED:  n_remove++;
                    ST_EMPTY:    n_empty++;
                    default:     n_full++;
                endcase
                if (shadow_count > deepest)
                    deepest = shadow_count;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_outcomes.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int ins_pct;
        int phase_left;
        int made;

        // directed: remove on an empty queue
        add_remove();
        // extremes of the key: zero and the largest 33-bit sum
        add_insert('0, '0, 16'h0000);
        add_insert('1, '1, 16'hffff);
        // equal keys through different submit/delay splits, then a sum that carries into bit 32
        add_insert('1, '0, 16'h1111);
        add_insert('0, '1, 16'h2222);
        add_insert(32'h8000_0000, 32'h8000_0000, 16'h3333);
        // tie with the head goes behind it
        add_insert('0, '0, 16'h4444);
        add_insert(32'd100, 32'd20, 16'h5555);
        add_insert(32'd60, 32'd60, 16'haaaa);
        add_insert(32'd120, 32'd0, 16'h5a5a);
        // fill up to the depth
        for (int i = 9; i < QUEUE_DEPTH; i++)
            add_insert(pick_time(), pick_time(), TAG_W'($urandom));
        // refused when full
        add_insert($urandom, $urandom, TAG_W'($urandom));
        // head pops, including the tie order at the front
        for (int i = 0; i < 4; i++)
            add_remove();
        // let everything drain once before the random part
        add_hold();

        // random part: phases that lean toward filling or toward draining,
        // so the queue swings through empty and full again and again
        made = 0;
        phase_left = 0;
        ins_pct = 50;
        while (made < RANDOM_REQS)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: ins_pct = 85;
                    1: ins_pct = 50;
                    default: ins_pct = 15;
                endcase
            end
            if ($urandom_range(0, 99) < ins_pct)
                add_insert(pick_time(), pick_time(), TAG_W'($urandom));
            else
                add_remove();
            phase_left--;
            made++;
            if (made % 450 == 0)
                add_hold();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all requests handed over and the last one taken
        while (job_cmds.size() != 0 || req_valid)
            @(posedge clk);
        while (due_outcomes.size() != 0)
            @(posedge clk);
        // room for a stray extra result
        repeat (QUEUE_DEPTH + 8) @(posedge clk);

        $display("ran %0d requests in %0d cycles: %0d inserts, %0d pops, %0d pops on empty,",
                 n_insert + n_remove + n_empty + n_full, cycle_count,
                 n_insert, n_remove, n_empty);
        $display("%0d inserts refused when full, deepest occupancy %0d, %0d results checked",
                 n_full, deepest, n_results);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/jpq_pkg.sv
rtl/core/jpq_ram.sv
rtl/core/sorted_job_priority_queue_core.sv
test/sorted_job_priority_queue_core_test.sv
